>>> rtl/matrix_scan_order_generator_defines.svh
// assertion macros for the matrix scan-order generator
// no dependencies; included by files that carry assertions
`ifndef MATRIX_SCAN_ORDER_GENERATOR_DEFINES_SVH
`define MATRIX_SCAN_ORDER_GENERATOR_DEFINES_SVH
`ifndef SYNTH
`define MSO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scan generator check failed");
`define MSO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scan generator check failed");
`else
`define MSO_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MSO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/mso_pkg.sv
// types and constants for the matrix scan-order generator
// no dependencies; imported by matrix_scan_order_generator
package mso_pkg;

    localparam int POS_W  = 7;
    localparam int DIAG_W = 8;
    localparam int VAL_W  = 32;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [DIAG_W-1:0] diag_t;
    typedef logic [1:0]        side_t;
    typedef logic signed [9:0] sint_t;

    typedef enum logic [2:0] {
        MODE_ROWS   = 3'd0,
        MODE_SPIRAL = 3'd1,
        MODE_SNAKE  = 3'd2,
        MODE_ZIG_R  = 3'd3,
        MODE_ZIG_D  = 3'd4,
        MODE_CONST  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        REG_FILL_MODE    = 2'd0,
        REG_ROW_COUNT    = 2'd1,
        REG_COLUMN_COUNT = 2'd2,
        REG_START_VALUE  = 2'd3
    } reg_idx_t;

endpackage

>>> rtl/matrix_scan_order_generator.sv
// matrix scan-order generator: row, spiral, snake, zigzag and constant fills
// depends on mso_pkg and matrix_scan_order_generator_defines.svh
//
//  channel | handshake           | payload
//  in      | in_valid / in_stall | restart
//  out     | out_valid/out_stall | row_index, column_index, fill_value, last_of_pass
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; the next position is formed combinationally from
// the current one, and the item lands in the output register in the cycle after it is taken
// in_stall rises only while a result sits in the output register and out_stall is high
// reset clears the position state and out_valid and sets the config registers to their reset values
// cfg_ready is always high; any register write ends the current pass
`include "matrix_scan_order_generator_defines.svh"

module matrix_scan_order_generator
    import mso_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    restart,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [5:0]              row_index,
    output logic [5:0]              column_index,
    output logic signed [VAL_W-1:0] fill_value,
    output logic                    last_of_pass,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [VAL_W-1:0]        cfg_data
);

    localparam pos_t ROW_LIM = pos_t'(MAX_ROWS < 127 ? MAX_ROWS : 127);
    localparam pos_t COL_LIM = pos_t'(MAX_COLS < 127 ? MAX_COLS : 127);

    logic [2:0]       fill_mode_reg;
    pos_t             row_count_reg;
    pos_t             column_count_reg;
    logic [VAL_W-1:0] start_value_reg;

    pos_t             cur_row_reg, cur_row_next;
    pos_t             cur_col_reg, cur_col_next;
    pos_t             layer_reg, layer_next;
    side_t            side_reg, side_next;
    diag_t            diag_reg, diag_next;
    logic [VAL_W-1:0] value_reg;
    logic             pass_active_reg;
    logic             more_next;
    logic             out_valid_reg;

    logic             in_accept;
    logic             cfg_write;
    logic             start;
    pos_t             rows_c, cols_c;
    pos_t             er, ec, el;
    side_t            es;
    diag_t            ed;
    logic [VAL_W-1:0] ev;
    mode_t            mode;

    function automatic pos_t clamp_cnt(pos_t v, pos_t lim);
        pos_t r;
        if (v == '0)
            r = pos_t'(1);
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

    function automatic sint_t to_s(pos_t v);
        return sint_t'({3'b000, v});
    endfunction

    assign in_accept = in_valid && !in_stall;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;

    assign rows_c = clamp_cnt(row_count_reg, ROW_LIM);
    assign cols_c = clamp_cnt(column_count_reg, COL_LIM);
    assign mode   = (fill_mode_reg > 3'(MODE_CONST)) ? MODE_ROWS : mode_t'(fill_mode_reg);

    // position the item emits: either the stored one or the first of a new pass
    assign start = restart || !pass_active_reg;
    assign er    = start ? '0 : cur_row_reg;
    assign ec    = start ? '0 : cur_col_reg;
    assign el    = start ? '0 : layer_reg;
    assign es    = start ? '0 : side_reg;
    assign ed    = start ? '0 : diag_reg;
    assign ev    = start ? start_value_reg : value_reg;

    always_comb
    begin
        sint_t      r_i, c_i, l_i, d_i, rows_i, cols_i, far, half, lk, fk, rr, cc, nd;
        logic       up, stepped, found, ok;
        logic [3:0] sk;
        cur_row_next = er;
        cur_col_next = ec;
        layer_next   = el;
        side_next    = es;
        diag_next    = ed;
        more_next    = 1'b0;
        r_i    = to_s(er);
        c_i    = to_s(ec);
        l_i    = to_s(el);
        d_i    = sint_t'({2'b00, ed});
        rows_i = to_s(rows_c);
        cols_i = to_s(cols_c);
        half   = to_s(cols_c >> 1);
        far    = cols_i - 10'sd1 - l_i;
        up     = 1'b0;
        stepped = 1'b0;
        found  = 1'b0;
        ok     = 1'b0;
        sk     = '0;
        lk     = '0;
        fk     = '0;
        rr     = '0;
        cc     = '0;
        nd     = d_i + 10'sd1;
        unique case (mode)
            MODE_SPIRAL:
            begin
                unique case (es)
                    2'd0:    stepped = c_i < far;
                    2'd1:    stepped = r_i < far;
                    2'd2:    stepped = c_i > l_i;
                    default: stepped = r_i > l_i + 10'sd1;
                endcase
                if (stepped)
                begin
                    more_next = 1'b1;
                    unique case (es)
                        2'd0:    cur_col_next = pos_t'(c_i + 10'sd1);
                        2'd1:    cur_row_next = pos_t'(r_i + 10'sd1);
                        2'd2:    cur_col_next = pos_t'(c_i - 10'sd1);
                        default: cur_row_next = pos_t'(r_i - 10'sd1);
                    endcase
                end
                else
                begin
                    // walk on to the next non-empty edge
                    for (int k = 1; k <= 8; k++)
                    begin
                        sk = {2'b00, es} + 4'(k);
                        lk = l_i + sint_t'({8'b0, sk[3:2]});
                        fk = cols_i - 10'sd1 - lk;
                        unique case (sk[1:0])
                            2'd0:
                            begin
                                rr = lk;
                                cc = lk;
                                ok = lk <= fk;
                            end
                            2'd1:
                            begin
                                rr = lk + 10'sd1;
                                cc = fk;
                                ok = lk + 10'sd1 <= fk;
                            end
                            2'd2:
                            begin
                                rr = fk;
                                cc = fk - 10'sd1;
                                ok = fk - 10'sd1 >= lk;
                            end
                            default:
                            begin
                                rr = fk - 10'sd1;
                                cc = lk;
                                ok = fk - 10'sd1 >= lk + 10'sd1;
                            end
                        endcase
                        if (!found)
                        begin
                            if (lk > half)
                                found = 1'b1;
                            else if (ok)
                            begin
                                found        = 1'b1;
                                more_next    = 1'b1;
                                layer_next   = pos_t'(lk);
                                side_next    = sk[1:0];
                                cur_row_next = pos_t'(rr);
                                cur_col_next = pos_t'(cc);
                            end
                        end
                    end
                end
            end
            MODE_SNAKE:
            begin
                if (!er[0] && (c_i + 10'sd1 < cols_i))
                begin
                    cur_col_next = pos_t'(c_i + 10'sd1);
                    more_next    = 1'b1;
                end
                else if (er[0] && (c_i > 10'sd0))
                begin
                    cur_col_next = pos_t'(c_i - 10'sd1);
                    more_next    = 1'b1;
                end
                else if (r_i + 10'sd1 < rows_i)
                begin
                    cur_row_next = pos_t'(r_i + 10'sd1);
                    cur_col_next = er[0] ? '0 : pos_t'(cols_i - 10'sd1);
                    more_next    = 1'b1;
                end
            end
            MODE_ZIG_R, MODE_ZIG_D:
            begin
                up = ((mode == MODE_ZIG_R) == !ed[0]);
                if (up && (r_i > 10'sd0) && (c_i + 10'sd1 < cols_i))
                begin
                    cur_row_next = pos_t'(r_i - 10'sd1);
                    cur_col_next = pos_t'(c_i + 10'sd1);
                    more_next    = 1'b1;
                end
                else if (!up && (c_i > 10'sd0) && (r_i + 10'sd1 < rows_i))
                begin
                    cur_row_next = pos_t'(r_i + 10'sd1);
                    cur_col_next = pos_t'(c_i - 10'sd1);
                    more_next    = 1'b1;
                end
                else if (nd <= rows_i + cols_i - 10'sd2)
                begin
                    more_next = 1'b1;
                    diag_next = diag_t'(nd);
                    if (!up)
                    begin
                        rr = (nd < rows_i - 10'sd1) ? nd : rows_i - 10'sd1;
                        cur_row_next = pos_t'(rr);
                        cur_col_next = pos_t'(nd - rr);
                    end
                    else
                    begin
                        cc = (nd < cols_i - 10'sd1) ? nd : cols_i - 10'sd1;
                        cur_col_next = pos_t'(cc);
                        cur_row_next = pos_t'(nd - cc);
                    end
                end
            end
            default:
            begin
                if (c_i + 10'sd1 < cols_i)
                begin
                    cur_col_next = pos_t'(c_i + 10'sd1);
                    more_next    = 1'b1;
                end
                else if (r_i + 10'sd1 < rows_i)
                begin
                    cur_row_next = pos_t'(r_i + 10'sd1);
                    cur_col_next = '0;
                    more_next    = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_mode_reg    <= 3'(MODE_ROWS);
            row_count_reg    <= pos_t'(1);
            column_count_reg <= pos_t'(1);
            start_value_reg  <= '0;
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            layer_reg        <= '0;
            side_reg         <= '0;
            diag_reg         <= '0;
            value_reg        <= '0;
            pass_active_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                cur_row_reg     <= cur_row_next;
                cur_col_reg     <= cur_col_next;
                layer_reg       <= layer_next;
                side_reg        <= side_next;
                diag_reg        <= diag_next;
                value_reg       <= ev + VAL_W'(1);
                pass_active_reg <= more_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_write)
            begin
                pass_active_reg <= 1'b0;
                unique case (reg_idx_t'(cfg_index))
                    REG_FILL_MODE:    fill_mode_reg    <= cfg_data[2:0];
                    REG_ROW_COUNT:    row_count_reg    <= cfg_data[POS_W-1:0];
                    REG_COLUMN_COUNT: column_count_reg <= cfg_data[POS_W-1:0];
                    REG_START_VALUE:  start_value_reg  <= cfg_data;
                    default:          start_value_reg  <= start_value_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            row_index    <= er[5:0];
            column_index <= ec[5:0];
            fill_value   <= (mode == MODE_CONST) ? start_value_reg : ev;
            last_of_pass <= !more_next;
        end
    end

    `MSO_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, out_valid_reg)
    `MSO_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_accept, out_valid_reg)
    `MSO_ASSERT_NEXT(a_last_ends_pass, clk, rst_n, in_accept && !more_next, !pass_active_reg)

endmodule

>>> tb/tb_matrix_scan_order_generator.sv
// testbench for matrix_scan_order_generator: directed and random scans checked
// against an in-bench model of every fill pattern; depends on mso_pkg and the rtl
module tb_matrix_scan_order_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import mso_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int MAX_SIDE     = 64;

    typedef struct {
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
        logic        last;
    } scan_pos_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             restart = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [5:0]       row_index;
    logic [5:0]       column_index;
    logic signed [31:0] fill_value;
    logic             last_of_pass;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = REG_FILL_MODE;
    logic [31:0]      cfg_data = '0;

    // model registers and walk state
    logic [2:0]  mode_reg;
    logic [6:0]  rows_reg;
    logic [6:0]  cols_reg;
    logic [31:0] start_reg;
    int          pos_row;
    int          pos_col;
    int          spiral_lyr;
    int          spiral_sd;
    int          zig_diag;
    logic [31:0] value_acc;
    bit          pass_on;

    scan_pos_t pending_positions[$];
    int        error_count;
    int        items_sent;
    int        results_checked;
    int        passes_done;
    int        phase_count;
    int        cycle_count;
    int        stall_left;
    bit        quiet_phase;

    matrix_scan_order_generator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_index    (row_index),
        .column_index (column_index),
        .fill_value   (fill_value),
        .last_of_pass (last_of_pass),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_size(input logic [6:0] cnt);
        if (cnt == 7'd0)
            return 1;
        if (cnt > MAX_SIDE)
            return MAX_SIDE;
        return int'(cnt);
    endfunction

    function automatic bit spiral_corner(input int n, input int lyr, input int sd,
                                         output int r, output int c);
        int far_edge;
        far_edge = n - 1 - lyr;
        case (sd)
            0:
            begin
                r = lyr;
                c = lyr;
                return lyr <= far_edge;
            end
            1:
            begin
                r = lyr + 1;
                c = far_edge;
                return lyr + 1 <= far_edge;
            end
            2:
            begin
                r = far_edge;
                c = far_edge - 1;
                return far_edge - 1 >= lyr;
            end
            default:
            begin
                r = far_edge - 1;
                c = lyr;
                return far_edge - 1 >= lyr + 1;
            end
        endcase
    endfunction

    function automatic bit advance_spiral(input int n);
        int far_edge;
        int lyr;
        int sd;
        int r;
        int c;
        far_edge = n - 1 - spiral_lyr;
        case (spiral_sd)
            0:
                if (pos_col < far_edge)
                begin
                    pos_col++;
                    return 1'b1;
                end
            1:
                if (pos_row < far_edge)
                begin
                    pos_row++;
                    return 1'b1;
                end
            2:
                if (pos_col > spiral_lyr)
                begin
                    pos_col--;
                    return 1'b1;
                end
            default:
                if (pos_row > spiral_lyr + 1)
                begin
                    pos_row--;
                    return 1'b1;
                end
        endcase
        lyr = spiral_lyr;
        sd  = spiral_sd;
        forever
        begin
            sd++;
            if (sd > 3)
            begin
                sd = 0;
                lyr++;
            end
            if (lyr > n / 2)
                return 1'b0;
            if (spiral_corner(n, lyr, sd, r, c))
            begin
                spiral_lyr = lyr;
                spiral_sd  = sd;
                pos_row    = r;
                pos_col    = c;
                return 1'b1;
            end
        end
    endfunction

    function automatic bit advance_zigzag(input int rows, input int cols, input bit right_first);
        bit up;
        int d;
        up = (right_first == ((zig_diag & 1) == 0));
        if (up)
        begin
            if (pos_row > 0 && pos_col + 1 < cols)
            begin
                pos_row--;
                pos_col++;
                return 1'b1;
            end
        end
        else
        begin
            if (pos_col > 0 && pos_row + 1 < rows)
            begin
                pos_row++;
                pos_col--;
                return 1'b1;
            end
        end
        d = zig_diag + 1;
        if (d > rows + cols - 2)
            return 1'b0;
        zig_diag = d;
        if (!up)
        begin
            pos_row = (d < rows - 1) ? d : rows - 1;
            pos_col = d - pos_row;
        end
        else
        begin
            pos_col = (d < cols - 1) ? d : cols - 1;
            pos_row = d - pos_col;
        end
        return 1'b1;
    endfunction

    function automatic bit advance_rows(input int rows, input int cols);
        if (pos_col + 1 < cols)
        begin
            pos_col++;
            return 1'b1;
        end
        if (pos_row + 1 < rows)
        begin
            pos_row++;
            pos_col = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit advance_snake(input int rows, input int cols);
        if ((pos_row & 1) == 0)
        begin
            if (pos_col + 1 < cols)
            begin
                pos_col++;
                return 1'b1;
            end
        end
        else if (pos_col > 0)
        begin
            pos_col--;
            return 1'b1;
        end
        if (pos_row + 1 >= rows)
            return 1'b0;
        pos_row++;
        pos_col = (pos_row & 1) ? cols - 1 : 0;
        return 1'b1;
    endfunction

    function automatic void predict_position(input bit rbit);
        int        rows;
        int        cols;
        mode_t     m;
        bit        more;
        scan_pos_t e;
        rows = clamp_size(rows_reg);
        cols = clamp_size(cols_reg);
        m = (mode_reg > 3'(MODE_CONST)) ? MODE_ROWS : mode_t'(mode_reg);
        if (rbit || !pass_on)
        begin
            pos_row    = 0;
            pos_col    = 0;
            spiral_lyr = 0;
            spiral_sd  = 0;
            zig_diag   = 0;
            value_acc  = start_reg;
            pass_on    = 1'b1;
        end
        e.row   = pos_row[5:0];
        e.col   = pos_col[5:0];
        e.value = (m == MODE_CONST) ? start_reg : value_acc;
        case (m)
            MODE_SPIRAL: more = advance_spiral(cols);
            MODE_SNAKE:  more = advance_snake(rows, cols);
            MODE_ZIG_R:  more = advance_zigzag(rows, cols, 1'b1);
            MODE_ZIG_D:  more = advance_zigzag(rows, cols, 1'b0);
            default:     more = advance_rows(rows, cols);
        endcase
        value_acc = value_acc + 32'd1;
        if (!more)
            pass_on = 1'b0;
        e.last = !more;
        pending_positions.push_back(e);
    endfunction

    function automatic void apply_reg(input reg_idx_t idx, input logic [31:0] data);
        case (idx)
            REG_FILL_MODE:    mode_reg  = data[2:0];
            REG_ROW_COUNT:    rows_reg  = data[6:0];
            REG_COLUMN_COUNT: cols_reg  = data[6:0];
            default:          start_reg = data;
        endcase
        pass_on = 1'b0;
    endfunction

    // output side: check on the falling edge, take at the next rising edge
    always @(negedge clk)
    begin
        scan_pos_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_positions.size() == 0)
            begin
                $display("%0t: unexpected item row %0d col %0d value %0h", $realtime,
                         row_index, column_index, fill_value);
                error_count++;
            end
            else
            begin
                e = pending_positions.pop_front();
                if (row_index !== e.row)
                begin
                    $display("%0t: row_index expected %0d actual %0d", $realtime,
                             e.row, row_index);
                    error_count++;
                end
                if (column_index !== e.col)
                begin
                    $display("%0t: column_index expected %0d actual %0d", $realtime,
                             e.col, column_index);
                    error_count++;
                end
                if (fill_value !== e.value)
                begin
                    $display("%0t: fill_value expected %h actual %h", $realtime,
                             e.value, fill_value);
                    error_count++;
                end
                if (last_of_pass !== e.last)
                begin
                    $display("%0t: last_of_pass expected %0b actual %0b", $realtime,
                             e.last, last_of_pass);
                    error_count++;
                end
                if (e.last)
                    passes_done++;
            end
            results_checked++;
            stall_left = quiet_phase ? 0 : $urandom_range(0, 15);
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input bit rbit);
        int gap;
        bit taken;
        gap = quiet_phase ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rbit;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            if (taken)
                predict_position(rbit);
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            if (taken)
                apply_reg(idx, data);
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] m, input logic [6:0] rows,
                             input logic [6:0] cols, input logic [31:0] start);
        logic [31:0] d;
        d = $urandom;
        d[2:0] = m;
        write_reg(REG_FILL_MODE, d);
        d = $urandom;
        d[6:0] = rows;
        write_reg(REG_ROW_COUNT, d);
        d = $urandom;
        d[6:0] = cols;
        write_reg(REG_COLUMN_COUNT, d);
        write_reg(REG_START_VALUE, start);
        phase_count++;
    endtask

    task automatic test_reset_state();
        quiet_phase = 1'b0;
        send_item(1'b0);
        send_item(1'b0);
        wait_idle();
    endtask

    task automatic test_each_mode();
        logic [31:0] starts[6];
        starts = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0000_0000, 32'hFFFF_FFFE, 32'h7FFF_FFFF};
        for (int i = 0; i < 6; i++)
        begin
            configure(3'(i), 7'd2, 7'd2, starts[i]);
            send_item(1'b0);
            send_item(1'b0);
            // restart partway through a pass in the odd-numbered modes
            send_item(i[0]);
            wait_idle();
        end
    endtask

    task automatic test_size_limits();
        // unused mode codes fall back to row order, counts clamp to the legal range
        configure(3'd7, 7'd0, 7'd127, 32'h1234_5678);
        send_item(1'b0);
        send_item(1'b0);
        wait_idle();
        write_reg(REG_FILL_MODE, 32'hFFFF_FFF6);
        send_item(1'b0);
        wait_idle();
    endtask

    function automatic logic [6:0] pick_count();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 2))
                    0:       return 7'd0;
                    1:       return 7'd64;
                    default: return 7'($urandom_range(65, 127));
                endcase
            1:       return 7'($urandom_range(1, 64));
            default: return 7'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [31:0] pick_start();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF - $urandom_range(0, 8);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_phases();
        int          target;
        int          n_items;
        bit          big;
        logic [2:0]  m;
        logic [31:0] d;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            big = ($urandom_range(0, 9) == 0);
            m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
            if (big)
            begin
                configure(m, $urandom_range(0, 1) ? 7'd64 : pick_count(),
                          $urandom_range(0, 1) ? 7'd64 : pick_count(), pick_start());
                n_items = $urandom_range(70, 200);
            end
            else
            begin
                if ($urandom_range(0, 1))
                begin
                    d = $urandom;
                    d[2:0] = m;
                    write_reg(REG_FILL_MODE, d);
                end
                if ($urandom_range(0, 1))
                begin
                    d = $urandom;
                    d[6:0] = pick_count();
                    write_reg(REG_ROW_COUNT, d);
                end
                if ($urandom_range(0, 1))
                begin
                    d = $urandom;
                    d[6:0] = pick_count();
                    write_reg(REG_COLUMN_COUNT, d);
                end
                if ($urandom_range(0, 1))
                    write_reg(REG_START_VALUE, pick_start());
                phase_count++;
                n_items = $urandom_range(4, 40);
            end
            repeat (n_items)
                send_item($urandom_range(0, 19) == 0);
            wait_idle();
        end
    endtask

    initial
    begin
        mode_reg        = MODE_ROWS;
        rows_reg        = 7'd1;
        cols_reg        = 7'd1;
        start_reg       = '0;
        pass_on         = 1'b0;
        value_acc       = '0;
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        passes_done     = 0;
        phase_count     = 0;
        cycle_count     = 0;
        stall_left      = 0;
        quiet_phase     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_each_mode();
        test_size_limits();
        test_random_phases();

        $display("%0d items over %0d register settings, %0d results checked, %0d full passes",
                 items_sent, phase_count, results_checked, passes_done);
        $display("all six fill patterns, unused mode codes, clamped sizes and restarts exercised");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
